>>> hdl/scgi_pkg.sv
// ----------------------------------------------------------------------------
// scgi_pkg
// Shared types and codes for the SCGI netstring header parser.
// ----------------------------------------------------------------------------
package scgi_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_BODY    = 3'd1,
    PH_TERM    = 3'd2,
    PH_DONE    = 3'd3,
    PH_INVALID = 3'd4,
    PH_TOOLONG = 3'd5,
    PH_CLOSED  = 3'd6
  } phase_e;

  // byte_kind codes
  localparam logic [2:0] KIND_OTHER     = 3'd0;
  localparam logic [2:0] KIND_KEY       = 3'd1;
  localparam logic [2:0] KIND_VALUE     = 3'd2;
  localparam logic [2:0] KIND_KEY_END   = 3'd3;
  localparam logic [2:0] KIND_VALUE_END = 3'd4;

  // status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_TOOLONG = 3'd3;
  localparam logic [2:0] ST_CLOSED  = 3'd4;

  // configuration register map
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam logic        REG_MAX_LENGTH   = 1'b0;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic [2:0] status;
  } result_t;

endpackage

>>> hdl/scgi_cfg.sv
// ----------------------------------------------------------------------------
// scgi_cfg
// APB-style register file holding max_length.
// ----------------------------------------------------------------------------
module scgi_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [scgi_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output logic [15:0]                          max_length_o
);

  logic [15:0] max_length_q;
  logic        reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= scgi_pkg::MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && (reg_sel == scgi_pkg::REG_MAX_LENGTH)) begin
      max_length_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == scgi_pkg::REG_MAX_LENGTH) begin
      prdata = {16'd0, max_length_q};
    end
  end

  assign max_length_o = max_length_q;

endmodule

>>> hdl/scgi_core.sv
// ----------------------------------------------------------------------------
// scgi_core
// Per-byte parser state and result logic; state advances on each accept.
// ----------------------------------------------------------------------------
module scgi_core #(
  parameter int unsigned PREFIX_LIMIT = 16,
  parameter int unsigned LENGTH_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     stream_closed_i,
  input  logic                     new_request_i,
  input  logic [15:0]              max_length_i,
  output scgi_pkg::result_t        result_o
);

  localparam int unsigned CNT_W = $clog2(PREFIX_LIMIT + 1);
  localparam int unsigned PROD_W = LENGTH_BITS + 4;
  localparam int unsigned CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(PREFIX_LIMIT);

  scgi_pkg::phase_e       phase_q, phase_d;
  logic [LENGTH_BITS-1:0] length_q, length_d;
  logic                   digits_done_q, digits_done_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic                   in_value_q, in_value_d;

  logic [PROD_W-1:0]      prod;
  logic [LENGTH_BITS-1:0] length_acc;
  logic                   is_digit;
  logic                   is_final;
  logic                   too_long;
  logic [2:0]             kind;
  logic [2:0]             status;

  // length*10 + digit, saturating
  assign prod = (PROD_W'(length_q) << 3) + (PROD_W'(length_q) << 1)
              + PROD_W'(data_byte_i[3:0]);
  assign length_acc = (prod[PROD_W-1:LENGTH_BITS] != '0) ? '1 : prod[LENGTH_BITS-1:0];
  assign is_digit = (data_byte_i >= scgi_pkg::CHAR_ZERO) && (data_byte_i <= scgi_pkg::CHAR_NINE);
  assign too_long = CMP_W'(length_q) > CMP_W'(max_length_i);
  assign is_final = (phase_q == scgi_pkg::PH_DONE) || (phase_q == scgi_pkg::PH_INVALID) ||
                    (phase_q == scgi_pkg::PH_TOOLONG) || (phase_q == scgi_pkg::PH_CLOSED);

  always_comb begin
    phase_d       = phase_q;
    length_d      = length_q;
    digits_done_d = digits_done_q;
    count_d       = count_q;
    remain_d      = remain_q;
    in_value_d    = in_value_q;
    kind          = scgi_pkg::KIND_OTHER;

    if (new_request_i) begin
      phase_d       = scgi_pkg::PH_PREFIX;
      length_d      = '0;
      digits_done_d = 1'b0;
      count_d       = '0;
      remain_d      = '0;
      in_value_d    = 1'b0;
    end else if (stream_closed_i) begin
      if (!is_final) begin
        phase_d = scgi_pkg::PH_CLOSED;
      end
    end else begin
      case (phase_q)
        scgi_pkg::PH_PREFIX: begin
          count_d = count_q + 1'b1;
          if (data_byte_i == scgi_pkg::CHAR_COLON) begin
            if (length_q == '0) begin
              phase_d = scgi_pkg::PH_INVALID;
            end else if (too_long) begin
              phase_d = scgi_pkg::PH_TOOLONG;
            end else begin
              remain_d = length_q;
              phase_d  = scgi_pkg::PH_BODY;
            end
          end else begin
            if (!digits_done_q && is_digit) begin
              length_d = length_acc;
            end else begin
              digits_done_d = 1'b1;
            end
            if (count_d >= CNT_LIMIT) begin
              phase_d = scgi_pkg::PH_INVALID;
            end
          end
        end
        scgi_pkg::PH_BODY: begin
          if (data_byte_i == scgi_pkg::CHAR_NUL) begin
            kind       = in_value_q ? scgi_pkg::KIND_VALUE_END : scgi_pkg::KIND_KEY_END;
            in_value_d = !in_value_q;
          end else begin
            kind = in_value_q ? scgi_pkg::KIND_VALUE : scgi_pkg::KIND_KEY;
          end
          if (remain_q != '0) begin
            remain_d = remain_q - 1'b1;
          end
          if (remain_d == '0) begin
            phase_d = scgi_pkg::PH_TERM;
          end
        end
        scgi_pkg::PH_TERM: begin
          phase_d = scgi_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end

    case (phase_d)
      scgi_pkg::PH_DONE:    status = scgi_pkg::ST_DONE;
      scgi_pkg::PH_INVALID: status = scgi_pkg::ST_INVALID;
      scgi_pkg::PH_TOOLONG: status = scgi_pkg::ST_TOOLONG;
      scgi_pkg::PH_CLOSED:  status = scgi_pkg::ST_CLOSED;
      default:              status = scgi_pkg::ST_BUSY;
    endcase
  end

  assign result_o.out_byte  = data_byte_i;
  assign result_o.byte_kind = kind;
  assign result_o.status    = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= scgi_pkg::PH_PREFIX;
      length_q      <= '0;
      digits_done_q <= 1'b0;
      count_q       <= '0;
      remain_q      <= '0;
      in_value_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      length_q      <= length_d;
      digits_done_q <= digits_done_d;
      count_q       <= count_d;
      remain_q      <= remain_d;
      in_value_q    <= in_value_d;
    end
  end

  // the missing-colon check must fire before the counter reaches the limit
  a_prefix_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == scgi_pkg::PH_PREFIX) |-> (count_q < CNT_LIMIT))
    else $error("prefix count reached limit while still in prefix");

  // body is only entered with bytes left to consume
  a_body_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == scgi_pkg::PH_BODY) |-> (remain_q != '0))
    else $error("body phase with zero bytes remaining");

  // a final phase only leaves on a new request
  a_final_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_final && !new_request_i) |=> (phase_q == $past(phase_q)))
    else $error("final phase left without new request");

endmodule

>>> hdl/scgi_obuf.sv
// ----------------------------------------------------------------------------
// scgi_obuf
// Result register with a skid entry; decouples input stall from output stall.
// ----------------------------------------------------------------------------
module scgi_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  scgi_pkg::result_t  data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output scgi_pkg::result_t  data_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  scgi_pkg::result_t main_q, skid_q;
  logic              pop;
  logic              load_main;
  logic              load_skid;
  logic              main_from_skid;

  assign pop = main_v_q && !stall_i;

  always_comb begin
    main_v_d       = main_v_q;
    skid_v_d       = skid_v_q;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    main_from_skid = 1'b0;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_v_d       = 1'b1;
        skid_v_d       = 1'b0;
        load_main      = 1'b1;
        main_from_skid = 1'b1;
      end else begin
        main_v_d  = push_i;
        load_main = push_i;
      end
    end else if (push_i) begin
      skid_v_d  = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main) begin
      main_q <= main_from_skid ? skid_q : data_i;
    end
    if (load_skid) begin
      skid_q <= data_i;
    end
  end

  assign full_o  = skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  // skid entry is only used behind a held result
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry valid while result register empty");

  // a push while the skid entry is in use would drop a result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !push_i)
    else $error("push while skid entry full");

endmodule

>>> hdl/scgi_header_parser.sv
// ----------------------------------------------------------------------------
// scgi_header_parser
// SCGI netstring header parser, one request byte per transaction.
// ----------------------------------------------------------------------------
// Input channel: data_byte_i, stream_closed_i, new_request_i with
// in_valid_i / in_stall_o. Output channel: out_byte_o, byte_kind_o, status_o
// with out_valid_o / out_stall_i. Each input transaction yields exactly one
// output transaction, in order.
// The parser state updates at the accepting edge, and the result is registered
// (in the result register, or in the skid entry) before it is offered.
// Throughput is one byte per cycle while in_stall_o is low; the per-byte state
// update (a x10 accumulate, a length compare, a down counter) is combinational.
// When the receiver stalls, the held result stays on the output and one more
// byte is taken into a skid entry; in_stall_o then rises until it drains.
// Reset clears the parser to the prefix phase and sets max_length to 65535.
// max_length is written over the APB port (byte address 0); the user must do so only while idle, unenforced.
// new_request_i restarts parsing; stream_closed_i ends it with status closed.
// ----------------------------------------------------------------------------
module scgi_header_parser #(
  parameter int unsigned PREFIX_LIMIT = 16,
  parameter int unsigned LENGTH_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             stream_closed_i,
  input  logic                             new_request_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       out_byte_o,
  output logic [2:0]                       byte_kind_o,
  output logic [2:0]                       status_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scgi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic              accept;
  logic              buf_full;
  logic [15:0]       max_length;
  scgi_pkg::result_t core_result;
  scgi_pkg::result_t out_result;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  scgi_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_length_o (max_length)
  );

  scgi_core #(
    .PREFIX_LIMIT (PREFIX_LIMIT),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .stream_closed_i (stream_closed_i),
    .new_request_i   (new_request_i),
    .max_length_i    (max_length),
    .result_o        (core_result)
  );

  scgi_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (core_result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_result)
  );

  assign out_byte_o  = out_result.out_byte;
  assign byte_kind_o = out_result.byte_kind;
  assign status_o    = out_result.status;

endmodule

>>> tb/scgi_header_parser_test.sv
// ----------------------------------------------------------------------------
// scgi_header_parser_test
// Self-checking testbench for the SCGI netstring header parser. Drives request
// byte streams (well-formed headers, bad prefixes, oversized lengths, closed
// streams and noise) under random source and sink idling, predicts every
// result with a behavioral parser and checks the output field by field.
// ----------------------------------------------------------------------------
module scgi_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PREFIX_LIMIT = 16;
  localparam int unsigned CFG_ADDR_W   = scgi_pkg::CFG_ADDR_W;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i;
  logic                  stream_closed_i;
  logic                  new_request_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            out_byte_o;
  logic [2:0]            byte_kind_o;
  logic [2:0]            status_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  scgi_header_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .stream_closed_i (stream_closed_i),
    .new_request_i   (new_request_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_kind_o     (byte_kind_o),
    .status_o        (status_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // parser state mirror
  scgi_pkg::phase_e ps_phase;
  logic [15:0]      ps_len;
  logic             ps_digits_done;
  logic [4:0]       ps_prefix_cnt;
  logic [15:0]      ps_left;
  logic             ps_in_value;
  logic [15:0]      cfg_max_len;

  scgi_pkg::result_t expected_results[$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  bit      src_gaps = 1'b0;
  bit      sink_gaps = 1'b0;
  int      hold_cycles = 0;
  int      stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function void clear_parser();
    ps_phase       = scgi_pkg::PH_PREFIX;
    ps_len         = '0;
    ps_digits_done = 1'b0;
    ps_prefix_cnt  = '0;
    ps_left        = '0;
    ps_in_value    = 1'b0;
  endfunction

  function automatic logic [2:0] held_code(input scgi_pkg::phase_e p);
    case (p)
      scgi_pkg::PH_DONE:    return scgi_pkg::ST_DONE;
      scgi_pkg::PH_INVALID: return scgi_pkg::ST_INVALID;
      scgi_pkg::PH_TOOLONG: return scgi_pkg::ST_TOOLONG;
      scgi_pkg::PH_CLOSED:  return scgi_pkg::ST_CLOSED;
      default:              return scgi_pkg::ST_BUSY;
    endcase
  endfunction

  // advance the mirrored parser by one byte, return the expected result
  function scgi_pkg::result_t parse_byte(input logic [7:0] b, input logic closed,
                                         input logic fresh);
    scgi_pkg::result_t r;
    logic [31:0]       acc;
    r.out_byte  = b;
    r.byte_kind = scgi_pkg::KIND_OTHER;
    if (fresh) begin
      clear_parser();
      r.status = scgi_pkg::ST_BUSY;
      return r;
    end
    if (closed) begin
      if (ps_phase < scgi_pkg::PH_DONE) ps_phase = scgi_pkg::PH_CLOSED;
      r.status = held_code(ps_phase);
      return r;
    end
    case (ps_phase)
      scgi_pkg::PH_PREFIX: begin
        ps_prefix_cnt = ps_prefix_cnt + 5'd1;
        if (b == scgi_pkg::CHAR_COLON) begin
          // zero length is checked before the size limit
          if (ps_len == 16'd0) ps_phase = scgi_pkg::PH_INVALID;
          else if (ps_len > cfg_max_len) ps_phase = scgi_pkg::PH_TOOLONG;
          else begin
            ps_left  = ps_len;
            ps_phase = scgi_pkg::PH_BODY;
          end
        end else begin
          if (!ps_digits_done && b >= scgi_pkg::CHAR_ZERO && b <= scgi_pkg::CHAR_NINE) begin
            acc    = 32'(ps_len) * 32'd10 + 32'(b - scgi_pkg::CHAR_ZERO);
            ps_len = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
          end else begin
            ps_digits_done = 1'b1;
          end
          if (ps_prefix_cnt >= PREFIX_LIMIT) ps_phase = scgi_pkg::PH_INVALID;
        end
      end
      scgi_pkg::PH_BODY: begin
        if (b == scgi_pkg::CHAR_NUL) begin
          r.byte_kind = ps_in_value ? scgi_pkg::KIND_VALUE_END : scgi_pkg::KIND_KEY_END;
          ps_in_value = ~ps_in_value;
        end else begin
          r.byte_kind = ps_in_value ? scgi_pkg::KIND_VALUE : scgi_pkg::KIND_KEY;
        end
        if (ps_left > 16'd0) ps_left = ps_left - 16'd1;
        if (ps_left == 16'd0) ps_phase = scgi_pkg::PH_TERM;
      end
      scgi_pkg::PH_TERM: ps_phase = scgi_pkg::PH_DONE;
      default: ;
    endcase
    r.status = held_code(ps_phase);
    return r;
  endfunction

  // mostly short runs, now and then a long one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == scgi_pkg::CHAR_COLON);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return scgi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    if (r < 50) return scgi_pkg::CHAR_COLON;
    if (r < 60) return scgi_pkg::CHAR_NUL;
    return 8'($urandom);
  endfunction

  task automatic check_result();
    scgi_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: out_byte %0h byte_kind %0d status %0d",
             out_byte_o, byte_kind_o, status_o);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    if (out_byte_o !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
      mismatch_count++;
    end
    if (byte_kind_o !== want.byte_kind) begin
      $error("byte_kind: expected %0d, got %0d", want.byte_kind, byte_kind_o);
      mismatch_count++;
    end
    if (status_o !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status_o);
      mismatch_count++;
    end
  endtask

  // result side: check at the rising edge, choose stall at the falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result();
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i = 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (sink_gaps && $urandom_range(0, 99) < 20) begin
        stall_left  = pick_len() - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic closed = 1'b0,
                           input logic fresh = 1'b0);
    int gap;
    gap = (src_gaps && $urandom_range(0, 99) >= 55) ? pick_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    data_byte_i     = b;
    stream_closed_i = closed;
    new_request_i   = fresh;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(parse_byte(b, closed, fresh));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = CFG_ADDR_W'(4 * scgi_pkg::REG_MAX_LENGTH);
    pwdata  = {16'h0, v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_max_len = v;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // new request, optional leading zeros, length digits, optional junk, colon
  task automatic send_prefix(input int unsigned len, input bit with_junk);
    string digits;
    int    zeros;
    send_byte(8'($urandom), 1'($urandom), 1'b1);
    digits = $sformatf("%0d", len);
    zeros  = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
    repeat (zeros) send_byte(scgi_pkg::CHAR_ZERO);
    foreach (digits[i]) send_byte(digits[i]);
    if (with_junk) repeat ($urandom_range(1, 2)) send_byte(junk_byte());
    send_byte(scgi_pkg::CHAR_COLON);
  endtask

  task automatic send_body(input int unsigned len);
    repeat (len) begin
      if ($urandom_range(0, 99) < 25) send_byte(scgi_pkg::CHAR_NUL);
      else send_byte(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_directed();
    send_byte(8'hFF, 1'b1, 1'b1);  // new request wins over closed
    send_byte("4");
    send_byte("x");                // digits end here, the 5 is ignored
    send_byte("5");
    send_byte(scgi_pkg::CHAR_COLON);
    send_byte("k");
    send_byte(scgi_pkg::CHAR_NUL);
    send_byte("v");
    send_byte(scgi_pkg::CHAR_NUL);
    send_byte("Z");                // terminator
    send_byte(8'h80);
    send_byte(8'h01, 1'b1);        // closed after completion keeps done
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(scgi_pkg::CHAR_COLON);  // zero length
    send_byte(8'h00, 1'b0, 1'b1);
    repeat (6) send_byte("9");     // saturates at the length ceiling
    send_byte(scgi_pkg::CHAR_COLON);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55);
  endtask

  task automatic test_prefix_limit();
    send_byte(8'h3C, 1'b0, 1'b1);
    send_byte("3");
    repeat (PREFIX_LIMIT - 1) send_byte(junk_byte());
    send_byte(scgi_pkg::CHAR_COLON);
    // colon lands exactly on the last allowed prefix byte
    send_byte(8'h00, 1'b0, 1'b1);
    repeat (PREFIX_LIMIT - 2) send_byte(scgi_pkg::CHAR_ZERO);
    send_byte("3");
    send_byte(scgi_pkg::CHAR_COLON);
    send_body(3);
    send_byte(8'($urandom));
  endtask

  task automatic test_max_length();
    write_max_length(16'd1);
    send_prefix(1, 1'b0);
    send_body(1);
    send_byte(8'($urandom));
    send_prefix(2, 1'b0);
    send_byte(8'($urandom));
    write_max_length(16'd0);
    send_prefix(1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(scgi_pkg::CHAR_ZERO);
    send_byte(scgi_pkg::CHAR_COLON);
    write_max_length(16'hFFFE);
    send_prefix(99999, 1'b0);
    send_byte(8'($urandom), 1'b1);
    write_max_length(16'hFFFF);
  endtask

  // sink holds off while the source keeps pushing back to back
  task automatic test_output_hold();
    src_gaps    = 1'b0;
    sink_gaps   = 1'b0;
    hold_cycles = 150;
    send_prefix(30, 1'b0);
    send_body(30);
    send_byte("T");
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic run_random(input logic [15:0] max_len, input int n_items);
    int          stop_at;
    int          r;
    int unsigned len;
    int unsigned cap;
    write_max_length(max_len);
    stop_at = items_sent + n_items;
    cap     = (max_len < 12) ? max_len : 12;
    while (items_sent < stop_at) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70 && cap > 0) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, (max_len < 60) ? max_len : 60);
        else len = $urandom_range(1, cap);
        send_prefix(len, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) == 0) begin
          send_body($urandom_range(0, len - 1));
          send_byte(8'($urandom), 1'b1);
        end else begin
          send_body(len);
          send_byte(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end else if (r < 85 && max_len != 16'hFFFF) begin
        len = max_len + $urandom_range(1, 20);
        if (len > 65535) len = 65535;
        send_prefix(len, 1'b0);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end else begin
        if ($urandom_range(0, 1)) send_byte(8'($urandom), 1'b0, 1'b1);
        repeat ($urandom_range(3, 20)) send_byte(noise_byte(), $urandom_range(0, 19) == 0);
      end
    end
  endtask

  task automatic test_random();
    run_random(16'hFFFF, 180);
    run_random(16'd8, 130);
    run_random(16'd40, 130);
    run_random(16'($urandom_range(1, 65535)), 130);
    run_random(16'd1, 80);
    run_random(16'd0, 80);
    run_random(16'hFFFF, 80);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    stream_closed_i = 1'b0;
    new_request_i   = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cfg_max_len     = scgi_pkg::MAX_LENGTH_RESET;
    clear_parser();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni    = 1'b1;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;

    test_directed();
    test_prefix_limit();
    test_max_length();
    test_output_hold();
    test_random();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/scgi_pkg.sv
hdl/scgi_cfg.sv
hdl/scgi_core.sv
hdl/scgi_obuf.sv
hdl/scgi_header_parser.sv
tb/scgi_header_parser_test.sv
